FILE: rtl/iirbp_pkg.sv
// ============================================================================
// iirbp_pkg
// Shared types, constants, coefficient table, microcode ROM and saturation
// helpers for the four-section band-pass biquad cascade.
// ============================================================================
package iirbp_pkg;

    // Stream layout.
    localparam int SAMPLE_W   = 24;
    localparam int TS_W       = 32;
    localparam int NUM_FIELDS = 4;
    localparam int TDATA_W    = ((NUM_FIELDS * SAMPLE_W + TS_W + 7) / 8) * 8;

    // Configuration defaults and limits.
    localparam int DEFAULT_CHANNELS = 4;
    localparam int DEFAULT_SECTIONS = 4;
    localparam int TABLE_IDX_W      = 2;

    // Fixed-point formats.
    localparam int SAMPLE_FRAC = 16;
    localparam int DELAY_W     = 48;
    localparam int COEF_W      = 33;
    localparam int COEF_FRAC   = 30;
    localparam int HALF_W      = 24;
    localparam int PROD_W      = COEF_W + HALF_W + 1;
    localparam int PACC_W      = PROD_W + HALF_W;
    localparam int ACC_W       = PACC_W - COEF_FRAC;

    // Microcode program counter width.
    localparam int PC_W = 5;

    typedef enum logic [2:0] {
        COEF_B0,
        COEF_B1,
        COEF_B2,
        COEF_A1,
        COEF_A2
    } coef_sel_t;

    typedef enum logic [1:0] {
        OPND_D0,
        OPND_D1,
        OPND_W
    } opnd_t;

    typedef enum logic {
        HALF_LO,
        HALF_HI
    } half_t;

    typedef enum logic [1:0] {
        PACC_HOLD,
        PACC_LOAD,
        PACC_ADD
    } pacc_op_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_X,
        ACC_SUB,
        ACC_ADD,
        ACC_SAT_W
    } acc_op_t;

    typedef enum logic [1:0] {
        X_HOLD,
        X_LOAD_SAMPLE,
        X_LOAD_ACC
    } x_op_t;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_SEC_LOOP,
        JMP_CH_LOOP,
        JMP_WAIT_OUT,
        JMP_ALWAYS
    } jump_t;

    // Program steps. One biquad section runs from ST_SEC_START to ST_SEC_END.
    typedef enum logic [PC_W-1:0] {
        ST_IDLE,
        ST_CH_START,
        ST_SEC_START,
        ST_A1_LO,
        ST_A1_HI,
        ST_A2_LO,
        ST_A2_HI,
        ST_B1_LO,
        ST_B1_HI,
        ST_B2_LO,
        ST_B2_HI,
        ST_B0_LO,
        ST_B0_HI,
        ST_ACC_B2,
        ST_GAP,
        ST_ACC_B0,
        ST_SEC_END,
        ST_CH_END,
        ST_DONE
    } pc_step_t;

    // One horizontal control word.
    typedef struct packed {
        coef_sel_t coef;
        opnd_t     opnd;
        half_t     half;
        pacc_op_t  pacc_op;
        acc_op_t   acc_op;
        x_op_t     x_op;
        logic      mem_wr;
        logic      res_wr;
        jump_t     jump;
        pc_step_t  target;
    } ucode_t;

    // Section coefficients in Q2.30.
    function automatic logic signed [COEF_W-1:0] coef_q30(
        input logic [TABLE_IDX_W-1:0] sec,
        input coef_sel_t              sel
    );
        logic signed [COEF_W-1:0] c;
        c = '0;
        case ({sec, sel})
            {2'd0, COEF_B0}: c = 33'sd67539375;
            {2'd0, COEF_B1}: c = 33'sd135078751;
            {2'd0, COEF_B2}: c = 33'sd67539375;
            {2'd0, COEF_A1}: c = -33'sd211719354;
            {2'd0, COEF_A2}: c = 33'sd55256442;
            {2'd1, COEF_B0}: c = 33'sd1073741824;
            {2'd1, COEF_B1}: c = 33'sd2147483648;
            {2'd1, COEF_B2}: c = 33'sd1073741824;
            {2'd1, COEF_A1}: c = -33'sd253752311;
            {2'd1, COEF_A2}: c = 33'sd498571053;
            {2'd2, COEF_B0}: c = 33'sd1073741824;
            {2'd2, COEF_B1}: c = -33'sd2147483648;
            {2'd2, COEF_B2}: c = 33'sd1073741824;
            {2'd2, COEF_A1}: c = -33'sd2084270169;
            {2'd2, COEF_A2}: c = 33'sd1011625438;
            {2'd3, COEF_B0}: c = 33'sd1073741824;
            {2'd3, COEF_B1}: c = -33'sd2147483648;
            {2'd3, COEF_B2}: c = 33'sd1073741824;
            {2'd3, COEF_A1}: c = -33'sd2121585641;
            {2'd3, COEF_A2}: c = 33'sd1048901911;
            default:         c = '0;
        endcase
        return c;
    endfunction

    // Microcode ROM. Each product takes a low and a high pass through the
    // shared multiplier; its rounded value passes through the product register,
    // the product accumulator and the rounding register to the accumulator.
    function automatic ucode_t ucode(input pc_step_t pc);
        ucode_t w;
        w = '0;
        unique case (pc)
            ST_IDLE: begin
                w.jump = JMP_WAIT_IN;
            end
            ST_CH_START: begin
                w.x_op = X_LOAD_SAMPLE;
            end
            ST_SEC_START: begin
                w.acc_op = ACC_LOAD_X;
            end
            ST_A1_LO: begin
                w.coef = COEF_A1;
                w.opnd = OPND_D0;
                w.half = HALF_LO;
            end
            ST_A1_HI: begin
                w.coef    = COEF_A1;
                w.opnd    = OPND_D0;
                w.half    = HALF_HI;
                w.pacc_op = PACC_LOAD;
            end
            ST_A2_LO: begin
                w.coef    = COEF_A2;
                w.opnd    = OPND_D1;
                w.half    = HALF_LO;
                w.pacc_op = PACC_ADD;
            end
            ST_A2_HI: begin
                w.coef    = COEF_A2;
                w.opnd    = OPND_D1;
                w.half    = HALF_HI;
                w.pacc_op = PACC_LOAD;
            end
            ST_B1_LO: begin
                w.coef    = COEF_B1;
                w.opnd    = OPND_D0;
                w.half    = HALF_LO;
                w.pacc_op = PACC_ADD;
                w.acc_op  = ACC_SUB;
            end
            ST_B1_HI: begin
                w.coef    = COEF_B1;
                w.opnd    = OPND_D0;
                w.half    = HALF_HI;
                w.pacc_op = PACC_LOAD;
            end
            ST_B2_LO: begin
                w.coef    = COEF_B2;
                w.opnd    = OPND_D1;
                w.half    = HALF_LO;
                w.pacc_op = PACC_ADD;
                w.acc_op  = ACC_SUB;
            end
            ST_B2_HI: begin
                w.coef    = COEF_B2;
                w.opnd    = OPND_D1;
                w.half    = HALF_HI;
                w.pacc_op = PACC_LOAD;
                w.acc_op  = ACC_SAT_W;
            end
            ST_B0_LO: begin
                w.coef    = COEF_B0;
                w.opnd    = OPND_W;
                w.half    = HALF_LO;
                w.pacc_op = PACC_ADD;
                w.acc_op  = ACC_ADD;
                w.mem_wr  = 1'b1;
            end
            ST_B0_HI: begin
                w.coef    = COEF_B0;
                w.opnd    = OPND_W;
                w.half    = HALF_HI;
                w.pacc_op = PACC_LOAD;
            end
            ST_ACC_B2: begin
                w.pacc_op = PACC_ADD;
                w.acc_op  = ACC_ADD;
            end
            ST_GAP: begin
                w.jump = JMP_NEXT;
            end
            ST_ACC_B0: begin
                w.acc_op = ACC_ADD;
            end
            ST_SEC_END: begin
                w.x_op   = X_LOAD_ACC;
                w.jump   = JMP_SEC_LOOP;
                w.target = ST_SEC_START;
            end
            ST_CH_END: begin
                w.res_wr = 1'b1;
                w.jump   = JMP_CH_LOOP;
                w.target = ST_CH_START;
            end
            ST_DONE: begin
                w.jump   = JMP_WAIT_OUT;
                w.target = ST_IDLE;
            end
            default: begin
                w.jump   = JMP_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // Saturate an accumulator value to a signed 48-bit delay word.
    function automatic logic signed [DELAY_W-1:0] sat_delay(
        input logic signed [ACC_W-1:0] v
    );
        logic [ACC_W-DELAY_W:0] top;
        top = v[ACC_W-1:DELAY_W-1];
        if (top == '0 || top == '1) begin
            return v[DELAY_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(DELAY_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DELAY_W-1){1'b1}}};
        end
    endfunction

    // Round a Q.16 cascade output half up to an integer and saturate to 24 bits.
    function automatic logic signed [SAMPLE_W-1:0] round_out(
        input logic signed [DELAY_W-1:0] v
    );
        logic [DELAY_W:0]                     t;
        logic [DELAY_W-SAMPLE_FRAC:0]         q;
        logic [DELAY_W-SAMPLE_FRAC-SAMPLE_W+1:0] top;
        t   = {v[DELAY_W-1], v}
            + {{(DELAY_W-SAMPLE_FRAC+1){1'b0}}, 1'b1, {(SAMPLE_FRAC-1){1'b0}}};
        q   = t[DELAY_W:SAMPLE_FRAC];
        top = q[DELAY_W-SAMPLE_FRAC:SAMPLE_W-1];
        if (top == '0 || top == '1) begin
            return q[SAMPLE_W-1:0];
        end else if (q[DELAY_W-SAMPLE_FRAC]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

FILE: rtl/iirbp_sequencer.sv
// ============================================================================
// iirbp_sequencer
// Microcode sequencer: program counter, microcode ROM lookup, and the
// section, channel and delay-row loop counters with their conditional jumps.
// ============================================================================
module iirbp_sequencer #(
    parameter int CHANNELS = iirbp_pkg::DEFAULT_CHANNELS,
    parameter int SECTIONS = iirbp_pkg::DEFAULT_SECTIONS,
    localparam int ROWS    = CHANNELS * SECTIONS,
    localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
    localparam int SEC_W   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1,
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 out_free,
    output iirbp_pkg::ucode_t    ctrl,
    output logic [CH_W-1:0]      ch,
    output logic [SEC_W-1:0]     sec,
    output logic [ROW_W-1:0]     row
);

    iirbp_pkg::pc_step_t pc_reg, pc_next, pc_inc;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [SEC_W-1:0]    sec_reg, sec_next;
    logic [ROW_W-1:0]    row_reg, row_next;

    // Control word for the current step.
    assign ctrl   = iirbp_pkg::ucode(pc_reg);
    assign pc_inc = iirbp_pkg::pc_step_t'(iirbp_pkg::PC_W'(pc_reg + 1'b1));
    assign ch     = ch_reg;
    assign sec    = sec_reg;
    assign row    = row_reg;

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= iirbp_pkg::ST_IDLE;
            ch_reg  <= '0;
            sec_reg <= '0;
            row_reg <= '0;
        end else begin
            pc_reg  <= pc_next;
            ch_reg  <= ch_next;
            sec_reg <= sec_next;
            row_reg <= row_next;
        end
    end

    // Next step and loop counters.
    always_comb begin
        pc_next  = pc_reg;
        ch_next  = ch_reg;
        sec_next = sec_reg;
        row_next = row_reg;
        unique case (ctrl.jump)
            iirbp_pkg::JMP_NEXT: begin
                pc_next = pc_inc;
            end
            iirbp_pkg::JMP_WAIT_IN: begin
                if (in_valid) begin
                    pc_next = pc_inc;
                end
            end
            iirbp_pkg::JMP_SEC_LOOP: begin
                // Delay rows are laid out channel-major, so the row simply
                // advances once per section.
                if (row_reg == ROW_W'(ROWS - 1)) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + 1'b1;
                end
                if (sec_reg != SEC_W'(SECTIONS - 1)) begin
                    sec_next = sec_reg + 1'b1;
                    pc_next  = ctrl.target;
                end else begin
                    sec_next = '0;
                    pc_next  = pc_inc;
                end
            end
            iirbp_pkg::JMP_CH_LOOP: begin
                if (ch_reg != CH_W'(CHANNELS - 1)) begin
                    ch_next = ch_reg + 1'b1;
                    pc_next = ctrl.target;
                end else begin
                    ch_next = '0;
                    pc_next = pc_inc;
                end
            end
            iirbp_pkg::JMP_WAIT_OUT: begin
                if (out_free) begin
                    pc_next = ctrl.target;
                end
            end
            iirbp_pkg::JMP_ALWAYS: begin
                pc_next = ctrl.target;
            end
            default: begin
                pc_next = iirbp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/iirbp_datapath.sv
// ============================================================================
// iirbp_datapath
// Shared multiply-accumulate datapath: one 33x25 multiplier used in two
// passes per product, a product accumulator with Q2.30 rounding, the section
// accumulator, and the delay-word row memory.
// ============================================================================
module iirbp_datapath #(
    parameter int CHANNELS = iirbp_pkg::DEFAULT_CHANNELS,
    parameter int SECTIONS = iirbp_pkg::DEFAULT_SECTIONS,
    localparam int ROWS    = CHANNELS * SECTIONS,
    localparam int SEC_W   = (SECTIONS > 1) ? $clog2(SECTIONS) : 1,
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  iirbp_pkg::ucode_t                       ctrl,
    input  logic [SEC_W-1:0]                        sec,
    input  logic [ROW_W-1:0]                        row,
    input  logic signed [iirbp_pkg::SAMPLE_W-1:0]   sample,
    output logic signed [iirbp_pkg::SAMPLE_W-1:0]   result
);

    localparam int DELAY_W   = iirbp_pkg::DELAY_W;
    localparam int HALF_W    = iirbp_pkg::HALF_W;
    localparam int PROD_W    = iirbp_pkg::PROD_W;
    localparam int PACC_W    = iirbp_pkg::PACC_W;
    localparam int ACC_W     = iirbp_pkg::ACC_W;
    localparam int SAMPLE_W  = iirbp_pkg::SAMPLE_W;
    localparam int FRAC      = iirbp_pkg::SAMPLE_FRAC;
    localparam int ROW_DW    = 2 * DELAY_W;
    localparam logic [PACC_W-1:0] RND_BIAS = PACC_W'(1) << (iirbp_pkg::COEF_FRAC - 1);

    logic signed [iirbp_pkg::COEF_W-1:0] coef;
    logic signed [DELAY_W-1:0]           d0, d1, opnd;
    logic signed [HALF_W:0]              opnd_half;
    logic signed [PROD_W-1:0]            prod_reg, prod_next;
    logic signed [PACC_W-1:0]            pacc_reg, pacc_next;
    logic [PACC_W-1:0]                   rnd_sum;
    logic signed [ACC_W-1:0]             rnd_reg, rnd_next;
    logic signed [ACC_W-1:0]             acc_reg, acc_next;
    logic signed [DELAY_W-1:0]           x_reg, x_next;
    logic signed [DELAY_W-1:0]           w_reg, w_next;
    logic [ROW_DW-1:0]                   rd_reg;
    logic [ROW_DW-1:0]                   row_mem [ROWS];
    logic [ROWS-1:0]                     valid_reg;

    // Delay words of the current row: d0 is w[n-1], d1 is w[n-2].
    assign d0 = rd_reg[DELAY_W-1:0];
    assign d1 = rd_reg[ROW_DW-1:DELAY_W];

    // Multiplier operands.
    assign coef = iirbp_pkg::coef_q30(iirbp_pkg::TABLE_IDX_W'(sec), ctrl.coef);

    always_comb begin
        unique case (ctrl.opnd)
            iirbp_pkg::OPND_D0: opnd = d0;
            iirbp_pkg::OPND_D1: opnd = d1;
            iirbp_pkg::OPND_W:  opnd = w_reg;
            default:            opnd = d0;
        endcase
        // The low half is unsigned, the high half carries the sign.
        if (ctrl.half == iirbp_pkg::HALF_HI) begin
            opnd_half = {opnd[DELAY_W-1], opnd[DELAY_W-1:HALF_W]};
        end else begin
            opnd_half = {1'b0, opnd[HALF_W-1:0]};
        end
    end

    assign prod_next = coef * opnd_half;

    // Product accumulator: low partial product, then the high one shifted up.
    always_comb begin
        case (ctrl.pacc_op)
            iirbp_pkg::PACC_LOAD: pacc_next = {{HALF_W{prod_reg[PROD_W-1]}}, prod_reg};
            iirbp_pkg::PACC_ADD:  pacc_next = pacc_reg + {prod_reg, {HALF_W{1'b0}}};
            default:              pacc_next = pacc_reg;
        endcase
    end

    // Round half up from Q.46 back to Q.16.
    assign rnd_sum  = pacc_reg + RND_BIAS;
    assign rnd_next = rnd_sum[PACC_W-1:iirbp_pkg::COEF_FRAC];

    // Section accumulator, feedback word and section input.
    always_comb begin
        acc_next = acc_reg;
        w_next   = w_reg;
        x_next   = x_reg;
        case (ctrl.acc_op)
            iirbp_pkg::ACC_LOAD_X: acc_next = {{(ACC_W-DELAY_W){x_reg[DELAY_W-1]}}, x_reg};
            iirbp_pkg::ACC_SUB:    acc_next = acc_reg - rnd_reg;
            iirbp_pkg::ACC_ADD:    acc_next = acc_reg + rnd_reg;
            iirbp_pkg::ACC_SAT_W: begin
                w_next   = iirbp_pkg::sat_delay(acc_reg);
                acc_next = '0;
            end
            default:               acc_next = acc_reg;
        endcase
        case (ctrl.x_op)
            iirbp_pkg::X_LOAD_SAMPLE: begin
                x_next = {{(DELAY_W-SAMPLE_W-FRAC){sample[SAMPLE_W-1]}}, sample,
                          {FRAC{1'b0}}};
            end
            iirbp_pkg::X_LOAD_ACC:    x_next = iirbp_pkg::sat_delay(acc_reg);
            default:                  x_next = x_reg;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        pacc_reg <= pacc_next;
        rnd_reg  <= rnd_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        w_reg    <= w_next;
    end

    // Delay row memory: the new row is {old d0, w}.
    always_ff @(posedge aclk) begin
        if (ctrl.mem_wr) begin
            row_mem[row] <= {d0, w_reg};
        end
        rd_reg <= valid_reg[row] ? row_mem[row] : '0;
    end

    // Rows never written since reset read as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctrl.mem_wr) begin
            valid_reg[row] <= 1'b1;
        end
    end

    assign result = iirbp_pkg::round_out(x_reg);

endmodule

FILE: rtl/iir_bandpass_biquad_cascade_top.sv
// ============================================================================
// iir_bandpass_biquad_cascade_top
// The microcode program runs 15 steps per section on one shared multiplier, and a
// new input word is taken only once the previous one has been through every
// channel and section and its results have moved to the output register.
// A finished word waits in the output register while the next one is taken.
// Reset clears the sequencer and the delay-row valid bits; all delay words
// then read as zero, with no clearing pass.
// ============================================================================
module iir_bandpass_biquad_cascade_top #(
    parameter int CHANNELS = iirbp_pkg::DEFAULT_CHANNELS,
    parameter int SECTIONS = iirbp_pkg::DEFAULT_SECTIONS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // sample_ch0, sample_ch1, sample_ch2, sample_ch3, time_stamp
    input  logic [iirbp_pkg::TDATA_W-1:0]  s_axis_tdata,
    input  logic                           s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // filtered_ch0, filtered_ch1, filtered_ch2, filtered_ch3, out_time_stamp
    output logic [iirbp_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                           m_axis_tlast
);

    localparam int NF       = iirbp_pkg::NUM_FIELDS;
    localparam int SAMPLE_W = iirbp_pkg::SAMPLE_W;
    localparam int TS_W     = iirbp_pkg::TS_W;
    localparam int TS_LSB   = NF * SAMPLE_W;
    localparam int FILT_CH  = (CHANNELS < NF) ? CHANNELS : NF;
    localparam int ROWS     = FILT_CH * SECTIONS;
    localparam int CH_W     = (FILT_CH > 1) ? $clog2(FILT_CH) : 1;
    localparam int SEC_W    = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;

    iirbp_pkg::ucode_t           ctrl;
    logic [CH_W-1:0]             ch;
    logic [SEC_W-1:0]            sec;
    logic [ROW_W-1:0]            row;
    logic                        in_fire;
    logic                        out_free;
    logic                        out_load;
    logic signed [SAMPLE_W-1:0]  dp_result;

    logic signed [SAMPLE_W-1:0]  in_sample_reg  [FILT_CH];
    logic [TS_W-1:0]             in_ts_reg;
    logic                        in_last_reg;
    logic signed [SAMPLE_W-1:0]  res_reg        [FILT_CH];
    logic signed [SAMPLE_W-1:0]  out_sample_reg [FILT_CH];
    logic [TS_W-1:0]             out_ts_reg;
    logic                        out_last_reg;
    logic                        m_valid_reg;

    // Handshake decode.
    assign s_axis_tready = (ctrl.jump == iirbp_pkg::JMP_WAIT_IN);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign out_load      = (ctrl.jump == iirbp_pkg::JMP_WAIT_OUT) && out_free;

    iirbp_sequencer #(
        .CHANNELS (FILT_CH),
        .SECTIONS (SECTIONS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .ctrl     (ctrl),
        .ch       (ch),
        .sec      (sec),
        .row      (row)
    );

    iirbp_datapath #(
        .CHANNELS (FILT_CH),
        .SECTIONS (SECTIONS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .sec      (sec),
        .row      (row),
        .sample   (in_sample_reg[ch]),
        .result   (dp_result)
    );

    // Input word capture.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            for (int i = 0; i < FILT_CH; i++) begin
                in_sample_reg[i] <= s_axis_tdata[i*SAMPLE_W +: SAMPLE_W];
            end
            in_ts_reg   <= s_axis_tdata[TS_LSB +: TS_W];
            in_last_reg <= s_axis_tlast;
        end
    end

    // Per-channel results, then the output register.
    always_ff @(posedge aclk) begin
        if (ctrl.res_wr) begin
            res_reg[ch] <= dp_result;
        end
        if (out_load) begin
            out_sample_reg <= res_reg;
            out_ts_reg     <= in_ts_reg;
            out_last_reg   <= in_last_reg;
        end
    end

    // Output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output packing; channels that are not built read zero.
    for (genvar i = 0; i < NF; i++) begin : g_out
        if (i < FILT_CH) begin : g_used
            assign m_axis_tdata[i*SAMPLE_W +: SAMPLE_W] = out_sample_reg[i];
        end else begin : g_zero
            assign m_axis_tdata[i*SAMPLE_W +: SAMPLE_W] = '0;
        end
    end

    assign m_axis_tdata[TS_LSB +: TS_W] = out_ts_reg;
    if (iirbp_pkg::TDATA_W > TS_LSB + TS_W) begin : g_pad
        assign m_axis_tdata[iirbp_pkg::TDATA_W-1:TS_LSB+TS_W] = '0;
    end
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tvalid = m_valid_reg;

endmodule
